// ===== sv/imuca_pkg.sv =====
// Shared types and constants of the IMU condition and align block.
`default_nettype none
package imuca_pkg;

    // Sample beat in.
    typedef struct packed {
        logic signed [15:0] raw_z;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_x;
    } t_imu_in;

    // Result beat out.
    typedef struct packed {
        logic               ok;
        logic signed [31:0] out_z;
        logic signed [31:0] out_y;
        logic signed [31:0] out_x;
    } t_imu_out;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSETS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_X    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z    = 3'd7;

    // Mode flag bit positions.
    localparam int unsigned MODE_ENABLE   = 0;
    localparam int unsigned MODE_OFFSET   = 1;
    localparam int unsigned MODE_DEADBAND = 2;
    localparam int unsigned MODE_ROTATE   = 3;

    // Axis alignment codes.
    localparam logic [2:0] ALIGN_CW0       = 3'd0;
    localparam logic [2:0] ALIGN_CW90      = 3'd1;
    localparam logic [2:0] ALIGN_CW180     = 3'd2;
    localparam logic [2:0] ALIGN_CW270     = 3'd3;
    localparam logic [2:0] ALIGN_CW0FLIP   = 3'd4;
    localparam logic [2:0] ALIGN_CW90FLIP  = 3'd5;
    localparam logic [2:0] ALIGN_CW180FLIP = 3'd6;
    localparam logic [2:0] ALIGN_CW270FLIP = 3'd7;

    localparam logic [23:0] SCALE_RESET = 24'd65536;

    // Output latency in clocks from the accepting edge to the strobe edge.
    localparam int unsigned PIPE_LATENCY = 6;

endpackage
`default_nettype wire

// ===== sv/imu_axis_condition_align_top.sv =====
// IMU sample conditioning and alignment pipeline, top level.
// Accepts one sample on every clock while o_busy is low (it is high only in reset
// and until r_ready is registered high after it). The result of each sample passes
// through the six register stages in order: offset, scale multiply, deadband and
// axis map, matrix multiply, sum, and round and saturate. The last stage loads the
// output register, which shows the result for one cycle with the o_valid strobe.
// Results come out in order.
// There is no output backpressure: the receiver cannot stall, so it must take every
// strobed beat. Write configuration only when no sample is in flight.
`default_nettype none
module imu_axis_condition_align_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    output logic                                o_busy,
    input  imuca_pkg::t_imu_in                  i_sample,
    output logic                                o_valid,
    output imuca_pkg::t_imu_out                 o_result,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [imuca_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [imuca_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import imuca_pkg::*;

    // Configuration registers.
    logic [3:0]  r_mode;
    logic [2:0]  r_align;
    logic [47:0] r_offsets;
    logic [23:0] r_scale;
    logic [47:0] r_deadband;
    logic [47:0] r_rot [3];
    logic        r_ready;

    // Pipeline registers.
    logic                r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [16:0]  r_d1  [3];
    logic signed [40:0]  r_p2  [3];
    logic signed [40:0]  r_a3  [3];
    logic signed [40:0]  r_a4  [3];
    logic signed [56:0]  r_m4  [3][3];
    logic signed [40:0]  r_a5  [3];
    logic signed [58:0]  r_acc5[3];

    logic                n_valid;
    t_imu_out            n_result;
    logic                accept;

    logic signed [16:0]  n_d   [3];
    logic signed [40:0]  n_prod[3];
    logic signed [40:0]  n_v   [3];
    logic signed [40:0]  n_a   [3];
    logic signed [31:0]  n_out [3];

    assign accept      = i_start & r_ready;
    assign o_busy      = ~r_ready;
    assign o_cfg_ready = r_ready;

    function automatic logic signed [31:0] round_rot(input logic signed [58:0] acc);
        logic signed [28:0] q;
        logic [29:0]        rem;
        logic               up;
        logic signed [29:0] qr;
        q   = acc[58:30];
        rem = acc[29:0];
        up  = (rem > 30'h2000_0000) || ((rem == 30'h2000_0000) && q[0]);
        qr  = 30'(q) + 30'(up);
        if (qr > 30'sd8388607) begin
            return 32'sh7FFF_FFFF;
        end else if (qr < -30'sd8388608) begin
            return 32'sh8000_0000;
        end else begin
            return {qr[23:0], 8'h00};
        end
    endfunction

    function automatic logic signed [31:0] round_lin(input logic signed [40:0] a);
        logic signed [32:0] q;
        logic [7:0]         rem;
        logic               up;
        logic signed [33:0] qr;
        q   = a[40:8];
        rem = a[7:0];
        up  = (rem > 8'h80) || ((rem == 8'h80) && q[0]);
        qr  = 34'(q) + 34'(up);
        if (qr > 34'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (qr < -34'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end else begin
            return qr[31:0];
        end
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= '0;
            r_align    <= ALIGN_CW0;
            r_offsets  <= '0;
            r_scale    <= SCALE_RESET;
            r_deadband <= '0;
            r_rot[0]   <= '0;
            r_rot[1]   <= '0;
            r_rot[2]   <= '0;
            r_ready    <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_valid && r_ready) begin
                unique case (i_cfg_index)
                    REG_MODE:     r_mode     <= i_cfg_data[3:0];
                    REG_ALIGN:    r_align    <= i_cfg_data[2:0];
                    REG_OFFSETS:  r_offsets  <= i_cfg_data;
                    REG_SCALE:    r_scale    <= i_cfg_data[23:0];
                    REG_DEADBAND: r_deadband <= i_cfg_data;
                    REG_ROT_X:    r_rot[0]   <= i_cfg_data;
                    REG_ROT_Y:    r_rot[1]   <= i_cfg_data;
                    REG_ROT_Z:    r_rot[2]   <= i_cfg_data;
                endcase
            end
        end
    end

    // Stage logic.
    always_comb begin
        n_d[0] = 17'(i_sample.raw_x);
        n_d[1] = 17'(i_sample.raw_y);
        n_d[2] = 17'(i_sample.raw_z);
        for (int k = 0; k < 3; k++) begin
            if (r_mode[MODE_OFFSET]) begin
                n_d[k] = n_d[k] - 17'($signed(r_offsets[16*k +: 16]));
            end
            n_prod[k] = r_d1[k] * $signed({1'b0, r_scale});
        end
        for (int k = 0; k < 3; k++) begin
            logic signed [40:0] mag;
            logic        [40:0] thr;
            mag = r_p2[k][40] ? -r_p2[k] : r_p2[k];
            thr = 41'({r_deadband[16*k +: 16], 8'h00});
            n_v[k] = (r_mode[MODE_DEADBAND] && ($unsigned(mag) < thr)) ? '0 : r_p2[k];
        end
        unique case (r_align)
            ALIGN_CW90: begin
                n_a[0] = n_v[1];  n_a[1] = -n_v[0]; n_a[2] = n_v[2];
            end
            ALIGN_CW180: begin
                n_a[0] = -n_v[0]; n_a[1] = -n_v[1]; n_a[2] = n_v[2];
            end
            ALIGN_CW270: begin
                n_a[0] = -n_v[1]; n_a[1] = n_v[0];  n_a[2] = n_v[2];
            end
            ALIGN_CW0FLIP: begin
                n_a[0] = -n_v[0]; n_a[1] = n_v[1];  n_a[2] = -n_v[2];
            end
            ALIGN_CW90FLIP: begin
                n_a[0] = n_v[1];  n_a[1] = n_v[0];  n_a[2] = -n_v[2];
            end
            ALIGN_CW180FLIP: begin
                n_a[0] = n_v[0];  n_a[1] = -n_v[1]; n_a[2] = -n_v[2];
            end
            ALIGN_CW270FLIP: begin
                n_a[0] = -n_v[1]; n_a[1] = -n_v[0]; n_a[2] = -n_v[2];
            end
            ALIGN_CW0: begin
                n_a[0] = n_v[0];  n_a[1] = n_v[1];  n_a[2] = n_v[2];
            end
        endcase
        for (int j = 0; j < 3; j++) begin
            n_out[j] = r_mode[MODE_ROTATE] ? round_rot(r_acc5[j]) : round_lin(r_a5[j]);
        end
        n_valid           = r_v5;
        n_result.ok       = r_mode[MODE_ENABLE];
        n_result.out_x    = r_mode[MODE_ENABLE] ? n_out[0] : '0;
        n_result.out_y    = r_mode[MODE_ENABLE] ? n_out[1] : '0;
        n_result.out_z    = r_mode[MODE_ENABLE] ? n_out[2] : '0;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= accept;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            o_valid <= n_valid;
        end
    end

    // Payload; free-running, qualified by the valid bits.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_d1[k] <= n_d[k];
            r_p2[k] <= n_prod[k];
            r_a3[k] <= n_a[k];
            r_a4[k] <= r_a3[k];
            r_a5[k] <= r_a4[k];
        end
        // Product of input axis k with its coefficient for output j.
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                r_m4[j][k] <= $signed(r_rot[k][16*j +: 16]) * r_a3[k];
            end
            r_acc5[j] <= 59'(r_m4[j][0]) + 59'(r_m4[j][1]) + 59'(r_m4[j][2]);
        end
        o_result <= n_result;
    end

endmodule
`default_nettype wire

// ===== sv/imuca_checker.sv =====
// Port-level checks of the IMU condition and align block, bound to its top level.
`default_nettype none
module imuca_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_start,
    input wire                          o_busy,
    input wire                          o_valid,
    input imuca_pkg::t_imu_out          o_result
);
    import imuca_pkg::*;

    // Every accepted beat returns exactly after the pipeline latency.
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##6 o_valid)
        else $error("accepted beat did not return after pipeline latency");

    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, PIPE_LATENCY))
        else $error("result strobe without matching accepted beat");

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.ok) |->
        (o_result.out_x == 32'sd0 && o_result.out_y == 32'sd0 && o_result.out_z == 32'sd0))
        else $error("disabled result carries nonzero data");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !o_busy)
        else $error("busy raised outside reset");

endmodule

bind imu_axis_condition_align_top imuca_checker u_imuca_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
`default_nettype wire

// ===== test/tb_imu_axis_condition_align_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the IMU sample condition and align pipeline.
module tb_imu_axis_condition_align_top;
    import imuca_pkg::*;

    localparam int unsigned     RANDOM_ITEMS = 1500;
    localparam longint unsigned CYCLE_LIMIT  = 200000;
    localparam longint          SAT_MAX      = 64'sd2147483647;
    localparam longint          SAT_MIN      = -64'sd2147483648;

    typedef struct {
        t_imu_in     smp;
        int unsigned gap;
    } t_pending;

    typedef struct {
        t_imu_in         smp;
        t_imu_out        res;
        longint unsigned cyc;
    } t_aligned;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    logic                  o_busy;
    t_imu_in               i_sample    = '0;
    logic                  o_valid;
    t_imu_out              o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Shadow copy of the register file.
    logic [3:0]  cfg_mode     = '0;
    logic [2:0]  cfg_align    = ALIGN_CW0;
    logic [47:0] cfg_offsets  = '0;
    logic [23:0] cfg_scale    = SCALE_RESET;
    logic [47:0] cfg_deadband = '0;
    logic [47:0] cfg_rot [3]  = '{48'd0, 48'd0, 48'd0};

    t_pending        sample_q[$];
    t_aligned        aligned_q[$];
    int unsigned     gap_style  = 0;
    int unsigned     wait_cnt   = 0;
    longint unsigned cycle_cnt  = 0;
    int unsigned     err_cnt    = 0;
    int unsigned     n_queued   = 0;
    int unsigned     n_sent     = 0;
    int unsigned     n_checked  = 0;
    int unsigned     n_writes   = 0;
    int unsigned     n_phases   = 0;

    imu_axis_condition_align_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cycle_cnt,
                     aligned_q.size());
            $display("imu_axis_condition_align_top: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        err_cnt++;
        $display("[%0t] ERROR %s", $time, msg);
    endtask

    function automatic logic [3:0] mode_word(bit en, bit sub, bit dbd, bit rot);
        logic [3:0] w;
        w = '0;
        w[MODE_ENABLE]   = en;
        w[MODE_OFFSET]   = sub;
        w[MODE_DEADBAND] = dbd;
        w[MODE_ROTATE]   = rot;
        return w;
    endfunction

    function automatic int unsigned reg_width(logic [CFG_IDX_W-1:0] idx);
        case (idx)
            REG_MODE:  return 4;
            REG_ALIGN: return 3;
            REG_SCALE: return 24;
            default:   return 48;
        endcase
    endfunction

    function automatic longint round_half_even(longint v, int unsigned sh);
        longint mag_v, q, rem, half;
        mag_v = (v < 0) ? -v : v;
        q     = mag_v >> sh;
        rem   = mag_v & ((longint'(1) << sh) - 1);
        half  = longint'(1) << (sh - 1);
        if (rem > half || (rem == half && q[0])) begin
            q++;
        end
        return (v < 0) ? -q : q;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > SAT_MAX) return 32'h7FFF_FFFF;
        if (v < SAT_MIN) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Zero result when disabled; else offset, scale, deadband, axis map, board matrix, round and clamp.
    function automatic t_imu_out align_sample(t_imu_in smp);
        t_imu_out    res;
        longint      v[3];
        longint      m[3];
        logic [31:0] o[3];
        longint      acc, mag, thr, r;
        int          k, j;
        res = '0;
        if (!cfg_mode[MODE_ENABLE]) return res;
        v[0] = longint'($signed(smp.raw_x));
        v[1] = longint'($signed(smp.raw_y));
        v[2] = longint'($signed(smp.raw_z));
        for (k = 0; k < 3; k++) begin
            if (cfg_mode[MODE_OFFSET]) begin
                v[k] -= longint'($signed(cfg_offsets[16*k +: 16]));
            end
            v[k] *= longint'(cfg_scale);
            if (cfg_mode[MODE_DEADBAND]) begin
                mag = (v[k] < 0) ? -v[k] : v[k];
                thr = longint'(cfg_deadband[16*k +: 16]) * 256;
                if (mag < thr) v[k] = 0;
            end
        end
        case (cfg_align)
            ALIGN_CW90:      m = '{v[1], -v[0], v[2]};
            ALIGN_CW180:     m = '{-v[0], -v[1], v[2]};
            ALIGN_CW270:     m = '{-v[1], v[0], v[2]};
            ALIGN_CW0FLIP:   m = '{-v[0], v[1], -v[2]};
            ALIGN_CW90FLIP:  m = '{v[1], v[0], -v[2]};
            ALIGN_CW180FLIP: m = '{v[0], -v[1], -v[2]};
            ALIGN_CW270FLIP: m = '{-v[1], -v[0], -v[2]};
            default:         m = '{v[0], v[1], v[2]};
        endcase
        for (j = 0; j < 3; j++) begin
            if (cfg_mode[MODE_ROTATE]) begin
                acc = 0;
                for (k = 0; k < 3; k++) begin
                    acc += longint'($signed(cfg_rot[k][16*j +: 16])) * m[k];
                end
                r = round_half_even(acc, 30) * 256;
            end else begin
                r = round_half_even(m[j], 8);
            end
            o[j] = clamp32(r);
        end
        res.out_x = o[0];
        res.out_y = o[1];
        res.out_z = o[2];
        res.ok    = 1'b1;
        return res;
    endfunction

    // Sample driver: present queued beats, hold while busy, idle per drawn gap.
    always @(posedge i_clk) begin : drive_p
        t_aligned nxt;
        if (!i_rst_n) begin
            i_start  <= 1'b0;
            wait_cnt <= 0;
        end else begin
            if (i_start && !o_busy) begin
                nxt.smp = i_sample;
                nxt.res = align_sample(i_sample);
                nxt.cyc = cycle_cnt;
                aligned_q.push_back(nxt);
                n_sent <= n_sent + 1;
            end
            if (!(i_start && o_busy)) begin
                if (sample_q.size() == 0) begin
                    i_start <= 1'b0;
                end else if (wait_cnt < sample_q[0].gap) begin
                    i_start  <= 1'b0;
                    wait_cnt <= wait_cnt + 1;
                end else begin
                    i_start  <= 1'b1;
                    i_sample <= sample_q[0].smp;
                    void'(sample_q.pop_front());
                    wait_cnt <= 0;
                end
            end
        end
    end

    // Result monitor: compare each strobed beat with the oldest expectation.
    always @(posedge i_clk) begin : check_p
        t_aligned want;
        if (i_rst_n && o_valid) begin
            if (aligned_q.size() == 0 || aligned_q[0].cyc >= cycle_cnt) begin
                report_mismatch($sformatf("result %h with no sample outstanding", o_result));
            end else begin
                want = aligned_q.pop_front();
                n_checked <= n_checked + 1;
                if (o_result.out_x !== want.res.out_x) begin
                    report_mismatch($sformatf("sample %h out_x got %0d want %0d",
                                              want.smp, o_result.out_x, want.res.out_x));
                end
                if (o_result.out_y !== want.res.out_y) begin
                    report_mismatch($sformatf("sample %h out_y got %0d want %0d",
                                              want.smp, o_result.out_y, want.res.out_y));
                end
                if (o_result.out_z !== want.res.out_z) begin
                    report_mismatch($sformatf("sample %h out_z got %0d want %0d",
                                              want.smp, o_result.out_z, want.res.out_z));
                end
                if (o_result.ok !== want.res.ok) begin
                    report_mismatch($sformatf("sample %h ok got %b want %b",
                                              want.smp, o_result.ok, want.res.ok));
                end
            end
        end
    end

    // Write one register, sometimes with junk above its width, and mirror it.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] keep, data;
        keep = (48'd1 << reg_width(idx)) - 48'd1;
        data = value & keep;
        if ($urandom_range(0, 1) == 1) begin
            data = data | (48'({$urandom(), $urandom()}) & ~keep);
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_writes++;
        data = data & keep;
        case (idx)
            REG_MODE:     cfg_mode     = data[3:0];
            REG_ALIGN:    cfg_align    = data[2:0];
            REG_OFFSETS:  cfg_offsets  = data;
            REG_SCALE:    cfg_scale    = data[23:0];
            REG_DEADBAND: cfg_deadband = data;
            REG_ROT_X:    cfg_rot[0]   = data;
            REG_ROT_Y:    cfg_rot[1]   = data;
            REG_ROT_Z:    cfg_rot[2]   = data;
            default:      ;
        endcase
    endtask

    task automatic queue_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        t_pending p;
        p.smp.raw_x = x;
        p.smp.raw_y = y;
        p.smp.raw_z = z;
        case (gap_style)
            0:       p.gap = 0;
            1:       p.gap = $urandom_range(0, 17);
            default: p.gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
        endcase
        sample_q.push_back(p);
        n_queued++;
    endtask

    // Hold the sender until every beat is accepted and every result is back.
    task automatic drain_pipe();
        do @(posedge i_clk);
        while (sample_q.size() != 0 || i_start || aligned_q.size() != 0);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
        n_phases++;
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] rand_signed16(int unsigned span);
        if ($urandom_range(0, 3) == 0) return 16'($urandom());
        return 16'(int'($urandom_range(0, 2 * span)) - int'(span));
    endfunction

    function automatic logic [15:0] rand_threshold();
        if ($urandom_range(0, 3) == 0) return 16'($urandom());
        return 16'($urandom_range(0, 16'h0400));
    endfunction

    function automatic logic [23:0] rand_scale();
        case ($urandom_range(0, 9))
            0:          return 24'd0;
            1:          return 24'hFF_FFFF;
            2, 3:       return 24'($urandom_range(0, 1023));
            4, 5, 6:    return 24'($urandom_range(32768, 131072));
            default:    return 24'($urandom());
        endcase
    endfunction

    // New register set for a random phase; some phases keep the old one.
    task automatic random_setup();
        if ($urandom_range(0, 4) == 0) return;
        if ($urandom_range(0, 4) == 0) begin
            cfg_write(REG_MODE, 48'($urandom_range(0, 15)));
        end else begin
            cfg_write(REG_MODE, 48'(4'($urandom_range(0, 15)) | mode_word(1, 0, 0, 0)));
        end
        if ($urandom_range(0, 1) == 1) cfg_write(REG_ALIGN, 48'($urandom_range(0, 7)));
        if ($urandom_range(0, 1) == 1) begin
            cfg_write(REG_OFFSETS,
                      {rand_signed16(512), rand_signed16(512), rand_signed16(512)});
        end
        if ($urandom_range(0, 1) == 1) cfg_write(REG_SCALE, 48'(rand_scale()));
        if ($urandom_range(0, 1) == 1) begin
            cfg_write(REG_DEADBAND, {rand_threshold(), rand_threshold(), rand_threshold()});
        end
        if ($urandom_range(0, 1) == 1) begin
            cfg_write(REG_ROT_X,
                      {rand_signed16(16384), rand_signed16(16384), rand_signed16(16384)});
        end
        if ($urandom_range(0, 1) == 1) begin
            cfg_write(REG_ROT_Y,
                      {rand_signed16(16384), rand_signed16(16384), rand_signed16(16384)});
        end
        if ($urandom_range(0, 1) == 1) begin
            cfg_write(REG_ROT_Z,
                      {rand_signed16(16384), rand_signed16(16384), rand_signed16(16384)});
        end
    endtask

    initial begin : stim_p
        int unsigned n_rand;
        int unsigned n;
        int          c;
        n_rand = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Disabled after reset: zero outputs, ok low.
        gap_style = 1;
        @(negedge i_clk);
        queue_sample(16'h7FFF, 16'h8000, 16'h0000);
        queue_sample(16'hFFFF, 16'h0001, 16'h8000);
        drain_pipe();

        // Board rotation with the all-zero reset matrix.
        cfg_write(REG_MODE, 48'(mode_word(1, 0, 0, 1)));
        @(negedge i_clk);
        queue_sample(16'h7FFF, 16'h8000, 16'h1234);
        queue_sample(16'h0001, 16'hFFFF, 16'h7FFF);
        drain_pipe();

        // Offset and full scale drive every axis of the first sample into saturation.
        cfg_write(REG_MODE, 48'(mode_word(1, 1, 0, 0)));
        cfg_write(REG_OFFSETS, {16'h0001, 16'h7FFF, 16'h8000});
        cfg_write(REG_SCALE, 48'h00_FF_FFFF);
        gap_style = 0;
        @(negedge i_clk);
        queue_sample(16'h7FFF, 16'h8000, 16'h8000);
        queue_sample(16'h8000, 16'h7FFF, 16'h7FFF);
        drain_pipe();

        // Half-unit products: check ties round to even.
        cfg_write(REG_MODE, 48'(mode_word(1, 0, 0, 0)));
        cfg_write(REG_SCALE, 48'd128);
        @(negedge i_clk);
        queue_sample(16'd1, 16'd3, 16'hFFFF);
        queue_sample(16'hFFFD, 16'd5, 16'h7FFF);
        drain_pipe();

        // Every axis map, including negation of the most negative axis.
        cfg_write(REG_SCALE, 48'(SCALE_RESET));
        gap_style = 1;
        for (c = ALIGN_CW0; c <= ALIGN_CW270FLIP; c++) begin
            cfg_write(REG_ALIGN, 48'(c));
            @(negedge i_clk);
            queue_sample(16'd1000, 16'hF830, 16'h8000);
            drain_pipe();
        end

        // Deadband: equal magnitude passes, smaller magnitude is zeroed.
        cfg_write(REG_ALIGN, 48'(ALIGN_CW0));
        cfg_write(REG_MODE, 48'(mode_word(1, 0, 1, 0)));
        cfg_write(REG_DEADBAND, {16'hFFFF, 16'h0200, 16'h0100});
        @(negedge i_clk);
        queue_sample(16'd1, 16'd1, 16'hFF01);
        queue_sample(16'hFFFF, 16'd2, 16'd256);
        drain_pipe();

        // Board matrix with mixed coefficients and half-unit sums.
        cfg_write(REG_MODE, 48'(mode_word(1, 0, 0, 1)));
        cfg_write(REG_SCALE, 48'd128);
        cfg_write(REG_ROT_X, {16'hE000, 16'h0000, 16'h4000});
        cfg_write(REG_ROT_Y, {16'h0000, 16'h4000, 16'h0003});
        cfg_write(REG_ROT_Z, {16'h4000, 16'hC000, 16'h0000});
        gap_style = 2;
        @(negedge i_clk);
        queue_sample(16'd256, 16'd768, 16'hFF00);
        queue_sample(16'hFD00, 16'd1, 16'd512);
        drain_pipe();

        // All stages on, most negative coefficients, full scale.
        cfg_write(REG_MODE, 48'(mode_word(1, 1, 1, 1)));
        cfg_write(REG_DEADBAND, 48'd0);
        cfg_write(REG_SCALE, 48'h00_FF_FFFF);
        cfg_write(REG_ROT_X, 48'h8000_8000_8000);
        cfg_write(REG_ROT_Y, 48'h8000_8000_8000);
        cfg_write(REG_ROT_Z, 48'h8000_8000_8000);
        @(negedge i_clk);
        queue_sample(16'h7FFF, 16'h8000, 16'h7FFF);
        queue_sample(16'h0000, 16'h0000, 16'h0000);
        drain_pipe();

        // Random phases; each ends with the sender held until the pipe is empty.
        while (n_rand < RANDOM_ITEMS) begin
            random_setup();
            gap_style = $urandom_range(0, 2);
            n = $urandom_range(20, 80);
            @(negedge i_clk);
            repeat (n) queue_sample(rand_axis(), rand_axis(), rand_axis());
            n_rand += n;
            drain_pipe();
        end

        $display("Queued %0d and sent %0d samples, checked %0d results over %0d phases.",
                 n_queued, n_sent, n_checked, n_phases);
        $display("Phases walked all axis maps, offsets, deadband, board matrix and saturation,",
                 " with %0d register writes.", n_writes);
        if (err_cnt == 0) begin
            $display("imu_axis_condition_align_top: match");
        end else begin
            $display("imu_axis_condition_align_top: mismatch");
        end
        $finish;
    end

endmodule
